// ===== sv/rrlpc_pkg.sv =====
// Shared types and codes for the row range LRU page cache.
package rrlpc_pkg;

    typedef enum logic [2:0] {
        OP_INSERT   = 3'd0,
        OP_FIND     = 3'd1,
        OP_UPDATE   = 3'd2,
        OP_CONTAINS = 3'd3,
        OP_ERASE    = 3'd4,
        OP_AFTER    = 3'd5,
        OP_CLEAR    = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_TOUCH_HOLD,
        ACT_REFRESH,
        ACT_INSERT,
        ACT_DROP_KEY,
        ACT_DROP_AFTER,
        ACT_CLEAR
    } act_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_SEL,
        S_MUL,
        S_APPLY,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [39:0] start;
        logic [15:0] rows;
        logic [15:0] cols;
        logic [23:0] cells;
    } page_t;

    typedef struct packed {
        act_t  act;
        page_t page;
        logic  evict_en;
    } cmd_t;

    typedef struct packed {
        logic valid;
        logic after;
        logic is_last;
        logic key_claim;
        logic hold_claim;
        logic free_claim;
    } cell_stat_t;

endpackage

// ===== sv/rrlpc_cell.sv =====
// One cache slot: descriptor, recency rank, match flags and priority chain links.
module rrlpc_cell #(
    parameter int SLOTS  = 8,
    parameter int RANK_W = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rrlpc_pkg::cmd_t     cmd,
    input  logic                m_en,
    input  logic                s_en,
    input  logic [RANK_W-1:0]   keep_rank,
    input  logic [RANK_W-1:0]   last_rank,
    input  logic [RANK_W-1:0]   sel_rank,
    input  logic [SLOTS-1:0]    drop_mask,
    input  logic                key_in,
    input  logic                hold_in,
    input  logic                free_in,
    output logic                key_out,
    output logic                hold_out,
    output logic                free_out,
    output rrlpc_pkg::cell_stat_t stat,
    output logic [RANK_W-1:0]   rank,
    output rrlpc_pkg::page_t    page
);

    logic                valid_reg, valid_next;
    logic [RANK_W-1:0]   rank_reg, rank_next;
    rrlpc_pkg::page_t    page_reg;
    logic                key_eq_reg, holds_reg, after_reg, evict_reg, last_reg;
    logic                key_claim_reg, hold_claim_reg, free_claim_reg;
    logic [40:0]         end_row;
    logic [40:0]         qrow;
    logic                free_flag;
    logic                key_claim, hold_claim, free_claim;
    logic                wr;
    logic                drop;
    logic [RANK_W-1:0]   below;

    assign qrow    = {1'b0, cmd.page.start};
    assign end_row = {1'b0, page_reg.start} + {25'b0, page_reg.rows};

    assign free_flag  = !valid_reg || (evict_reg && cmd.evict_en);
    assign key_claim  = key_eq_reg && !key_in;
    assign hold_claim = holds_reg && !hold_in;
    assign free_claim = free_flag && !free_in;
    assign key_out    = key_in || key_eq_reg;
    assign hold_out   = hold_in || holds_reg;
    assign free_out   = free_in || free_flag;

    assign stat.valid      = valid_reg;
    assign stat.after      = after_reg;
    assign stat.is_last    = last_reg;
    assign stat.key_claim  = key_claim;
    assign stat.hold_claim = hold_claim;
    assign stat.free_claim = free_claim;
    assign rank = rank_reg;
    assign page = page_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_eq_reg     <= 1'b0;
            holds_reg      <= 1'b0;
            after_reg      <= 1'b0;
            evict_reg      <= 1'b0;
            last_reg       <= 1'b0;
            key_claim_reg  <= 1'b0;
            hold_claim_reg <= 1'b0;
            free_claim_reg <= 1'b0;
        end
        else
        begin
            if (m_en)
            begin
                key_eq_reg <= valid_reg && (page_reg.start == cmd.page.start);
                holds_reg  <= valid_reg && ({1'b0, page_reg.start} <= qrow)
                              && (qrow < end_row);
                after_reg  <= valid_reg && (({1'b0, page_reg.start} >= qrow)
                              || (end_row > qrow));
                evict_reg  <= valid_reg && (rank_reg >= keep_rank);
                last_reg   <= valid_reg && (rank_reg == last_rank);
            end
            if (s_en)
            begin
                key_claim_reg  <= key_claim;
                hold_claim_reg <= hold_claim;
                free_claim_reg <= free_claim;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        wr         = 1'b0;
        drop       = 1'b0;
        below      = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (drop_mask[k] && (RANK_W'(k) < rank_reg))
                below = below + 1'b1;
        end
        case (cmd.act) inside
            rrlpc_pkg::ACT_TOUCH_HOLD, rrlpc_pkg::ACT_REFRESH:
            begin
                if ((cmd.act == rrlpc_pkg::ACT_REFRESH) ? key_claim_reg : hold_claim_reg)
                begin
                    rank_next = '0;
                    wr        = (cmd.act == rrlpc_pkg::ACT_REFRESH);
                end
                else if (valid_reg && (rank_reg < sel_rank))
                    rank_next = rank_reg + 1'b1;
            end
            rrlpc_pkg::ACT_INSERT:
            begin
                if (free_claim_reg)
                begin
                    valid_next = 1'b1;
                    rank_next  = '0;
                    wr         = 1'b1;
                end
                else if (valid_reg && evict_reg && cmd.evict_en)
                begin
                    valid_next = 1'b0;
                    rank_next  = '0;
                end
                else if (valid_reg)
                    rank_next = rank_reg + 1'b1;
            end
            rrlpc_pkg::ACT_DROP_KEY, rrlpc_pkg::ACT_DROP_AFTER:
            begin
                drop = (cmd.act == rrlpc_pkg::ACT_DROP_KEY) ? key_claim_reg : after_reg;
                if (drop)
                begin
                    valid_next = 1'b0;
                    rank_next  = '0;
                end
                else if (valid_reg)
                    rank_next = rank_reg - below;
            end
            rrlpc_pkg::ACT_CLEAR:
            begin
                valid_next = 1'b0;
                rank_next  = '0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            page_reg <= cmd.page;
    end

endmodule

// ===== sv/row_range_lru_page_cache.sv =====
// Top level: request sequencer, slot chain and result registers of the page cache.
// A request is accepted at the rising edge where start is high and busy is low.
// done is high for one cycle. A request passes through per-slot compare,
// priority selection along the slot chain, multiply for the cell index, state
// update and result, done being high in the result state. busy stays high
// through the done cycle, so a new request waits for the last; it is taken in the
// cycle after done at the earliest. The result ports are valid only while done
// is high and must be taken in that cycle. cfg_ready is always high; write
// capacity only while busy is low. After reset the cache is empty with capacity 8.
module row_range_lru_page_cache #(
    parameter int PAGE_SLOTS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    output logic         busy,
    input  logic [2:0]   op,
    input  logic [39:0]  row,
    input  logic [15:0]  row_span,
    input  logic [15:0]  columns_per_row,
    input  logic [23:0]  cells_held,
    input  logic signed [31:0] column,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [3:0]   cfg_data,
    output logic         done,
    output logic         hit,
    output logic [2:0]   slot,
    output logic [23:0]  cell_index,
    output logic         evicted,
    output logic [39:0]  evicted_start,
    output logic [3:0]   pages_in_use
);

    localparam int RANK_W = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(PAGE_SLOTS + 1);

    rrlpc_pkg::state_t state_reg, state_next;
    logic [3:0]  cap_reg;
    logic [2:0]  op_reg;
    rrlpc_pkg::page_t inpage_reg;
    logic [31:0] col_reg;

    logic [CNT_W-1:0]  count_now;
    logic [RANK_W-1:0] keep_rank, last_rank;
    logic              evict_en_reg;
    logic              m_en, s_en, cap_ok;

    rrlpc_pkg::cell_stat_t stat [PAGE_SLOTS];
    logic [RANK_W-1:0]     rank [PAGE_SLOTS];
    rrlpc_pkg::page_t      pdata [PAGE_SLOTS];
    logic [PAGE_SLOTS:0]   key_ch, hold_ch, free_ch;
    rrlpc_pkg::cmd_t       cmd;

    logic                  any_key_reg, any_hold_reg;
    logic [RANK_W-1:0]     key_slot_reg, hold_slot_reg, free_slot_reg;
    logic [RANK_W-1:0]     sel_rank_reg;
    logic [PAGE_SLOTS-1:0] mask_reg;
    rrlpc_pkg::page_t      hpage_reg;
    logic [39:0]           evstart_reg;

    logic [RANK_W-1:0]     key_slot_c, hold_slot_c, free_slot_c, key_rank_c, hold_rank_c;
    logic [PAGE_SLOTS-1:0] key_mask_c, after_mask_c;
    rrlpc_pkg::page_t      hpage_c;
    logic [39:0]           evstart_c;

    logic [31:0] prod_reg;
    logic [15:0] diff;
    logic [32:0] idx;
    logic        upd_ok;
    rrlpc_pkg::act_t act;

    logic        hit_reg;
    logic [RANK_W-1:0] slot_reg;
    logic [23:0] index_reg;
    logic        ev_reg;
    logic [39:0] evs_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= 4'd8;
        else if (cfg_valid && cfg_ready)
            cap_reg <= cfg_data;
    end

    always_comb
    begin
        count_now = '0;
        for (int i = 0; i < PAGE_SLOTS; i++)
            count_now = count_now + CNT_W'(stat[i].valid);
    end

    always_comb
    begin
        if (cap_reg == 4'd0)
            keep_rank = '0;
        else if (32'(cap_reg) > PAGE_SLOTS)
            keep_rank = RANK_W'(PAGE_SLOTS - 1);
        else
            keep_rank = RANK_W'(cap_reg - 4'd1);
        last_rank = RANK_W'(count_now - 1'b1);
        cap_ok    = (CNT_W + 1)'(count_now) > (CNT_W + 1)'(keep_rank);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrlpc_pkg::S_IDLE:  if (start) state_next = rrlpc_pkg::S_MATCH;
            rrlpc_pkg::S_MATCH: state_next = rrlpc_pkg::S_SEL;
            rrlpc_pkg::S_SEL:   state_next = rrlpc_pkg::S_MUL;
            rrlpc_pkg::S_MUL:   state_next = rrlpc_pkg::S_APPLY;
            rrlpc_pkg::S_APPLY: state_next = rrlpc_pkg::S_DONE;
            rrlpc_pkg::S_DONE:  state_next = rrlpc_pkg::S_IDLE;
            default:            state_next = rrlpc_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        busy = (state_reg != rrlpc_pkg::S_IDLE);
        done = (state_reg == rrlpc_pkg::S_DONE);
        m_en = (state_reg == rrlpc_pkg::S_MATCH);
        s_en = (state_reg == rrlpc_pkg::S_SEL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rrlpc_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg           <= op;
            inpage_reg.start <= row;
            inpage_reg.rows  <= row_span;
            inpage_reg.cols  <= columns_per_row;
            inpage_reg.cells <= cells_held;
            col_reg          <= column;
        end
        if (m_en)
            evict_en_reg <= cap_ok;
    end

    assign cmd.act      = act;
    assign cmd.page     = inpage_reg;
    assign cmd.evict_en = evict_en_reg;

    assign key_ch[0]  = 1'b0;
    assign hold_ch[0] = 1'b0;
    assign free_ch[0] = 1'b0;

    for (genvar g = 0; g < PAGE_SLOTS; g++)
    begin : g_cell
        rrlpc_cell #(
            .SLOTS  (PAGE_SLOTS),
            .RANK_W (RANK_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd),
            .m_en      (m_en),
            .s_en      (s_en),
            .keep_rank (keep_rank),
            .last_rank (last_rank),
            .sel_rank  (sel_rank_reg),
            .drop_mask (mask_reg),
            .key_in    (key_ch[g]),
            .hold_in   (hold_ch[g]),
            .free_in   (free_ch[g]),
            .key_out   (key_ch[g+1]),
            .hold_out  (hold_ch[g+1]),
            .free_out  (free_ch[g+1]),
            .stat      (stat[g]),
            .rank      (rank[g]),
            .page      (pdata[g])
        );
    end

    always_comb
    begin
        key_slot_c   = '0;
        hold_slot_c  = '0;
        free_slot_c  = '0;
        key_rank_c   = '0;
        hold_rank_c  = '0;
        key_mask_c   = '0;
        after_mask_c = '0;
        hpage_c      = '0;
        evstart_c    = '0;
        for (int i = 0; i < PAGE_SLOTS; i++)
        begin
            if (stat[i].key_claim)
            begin
                key_slot_c = RANK_W'(i);
                key_rank_c = rank[i];
                key_mask_c = key_mask_c | (PAGE_SLOTS'(1) << rank[i]);
            end
            if (stat[i].hold_claim)
            begin
                hold_slot_c = RANK_W'(i);
                hold_rank_c = rank[i];
                hpage_c     = pdata[i];
            end
            if (stat[i].free_claim)
                free_slot_c = RANK_W'(i);
            if (stat[i].after)
                after_mask_c = after_mask_c | (PAGE_SLOTS'(1) << rank[i]);
            if (stat[i].is_last)
                evstart_c = pdata[i].start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_en)
        begin
            any_key_reg   <= key_ch[PAGE_SLOTS];
            any_hold_reg  <= hold_ch[PAGE_SLOTS];
            key_slot_reg  <= key_slot_c;
            hold_slot_reg <= hold_slot_c;
            free_slot_reg <= free_slot_c;
            sel_rank_reg  <= (op_reg == rrlpc_pkg::OP_INSERT) ? key_rank_c : hold_rank_c;
            mask_reg      <= (op_reg == rrlpc_pkg::OP_AFTER) ? after_mask_c : key_mask_c;
            hpage_reg     <= hpage_c;
            evstart_reg   <= evstart_c;
        end
        if (state_reg == rrlpc_pkg::S_MUL)
            prod_reg <= diff * hpage_reg.cols;
    end

    assign diff   = 16'(inpage_reg.start - hpage_reg.start);
    assign idx    = {1'b0, prod_reg} + {2'b0, col_reg[30:0]};
    assign upd_ok = !col_reg[31] && any_hold_reg
                    && (col_reg[30:0] < {15'b0, hpage_reg.cols})
                    && (idx < {9'b0, hpage_reg.cells});

    always_comb
    begin
        act = rrlpc_pkg::ACT_NONE;
        if (state_reg == rrlpc_pkg::S_APPLY)
        begin
            unique case (op_reg)
                rrlpc_pkg::OP_INSERT:
                    act = any_key_reg ? rrlpc_pkg::ACT_REFRESH : rrlpc_pkg::ACT_INSERT;
                rrlpc_pkg::OP_FIND:
                    act = any_hold_reg ? rrlpc_pkg::ACT_TOUCH_HOLD : rrlpc_pkg::ACT_NONE;
                rrlpc_pkg::OP_UPDATE:
                    act = upd_ok ? rrlpc_pkg::ACT_TOUCH_HOLD : rrlpc_pkg::ACT_NONE;
                rrlpc_pkg::OP_ERASE:
                    act = any_key_reg ? rrlpc_pkg::ACT_DROP_KEY : rrlpc_pkg::ACT_NONE;
                rrlpc_pkg::OP_AFTER:
                    act = rrlpc_pkg::ACT_DROP_AFTER;
                rrlpc_pkg::OP_CLEAR:
                    act = rrlpc_pkg::ACT_CLEAR;
                default:
                    act = rrlpc_pkg::ACT_NONE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rrlpc_pkg::S_APPLY)
        begin
            hit_reg   <= 1'b0;
            slot_reg  <= '0;
            index_reg <= '0;
            ev_reg    <= 1'b0;
            evs_reg   <= '0;
            unique case (op_reg)
                rrlpc_pkg::OP_INSERT:
                begin
                    hit_reg  <= any_key_reg;
                    slot_reg <= any_key_reg ? key_slot_reg : free_slot_reg;
                    ev_reg   <= !any_key_reg && evict_en_reg;
                    evs_reg  <= (!any_key_reg && evict_en_reg) ? evstart_reg : 40'd0;
                end
                rrlpc_pkg::OP_FIND:
                begin
                    hit_reg  <= any_hold_reg;
                    slot_reg <= any_hold_reg ? hold_slot_reg : '0;
                end
                rrlpc_pkg::OP_UPDATE:
                begin
                    hit_reg   <= upd_ok;
                    slot_reg  <= upd_ok ? hold_slot_reg : '0;
                    index_reg <= upd_ok ? idx[23:0] : 24'd0;
                end
                rrlpc_pkg::OP_CONTAINS:
                begin
                    hit_reg  <= any_key_reg;
                    slot_reg <= any_key_reg ? key_slot_reg : '0;
                end
                default:
                begin
                    hit_reg <= 1'b0;
                end
            endcase
        end
    end

    assign hit           = hit_reg;
    assign slot          = 3'(slot_reg);
    assign cell_index    = index_reg;
    assign evicted       = ev_reg;
    assign evicted_start = evs_reg;
    assign pages_in_use  = 4'(count_now);

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held longer than one cycle");
    a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy) else $error("accepted request did not raise busy");
    a_evict_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted) |-> !hit) else $error("eviction reported on a refresh");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(pages_in_use) <= PAGE_SLOTS)) else $error("page count overflow");
    a_done_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == rrlpc_pkg::S_APPLY))
        else $error("result without update cycle");
    a_insert_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        (s_en && (op_reg == rrlpc_pkg::OP_INSERT)) |-> free_ch[PAGE_SLOTS])
        else $error("no free slot for insert");
`endif

endmodule
